/* rtl/sdf_pkg.sv */
package sdf_pkg;

	// Decimal digits held by the cell chain; enough for a 64-bit magnitude.
	localparam int NDIG = 20;
	localparam int DCNT_W = 5;

	localparam logic [6:0] CH_ZERO = 7'h30;
	localparam logic [6:0] CH_MINUS = 7'h2D;

	localparam logic [1:0] MODE_SHORT = 2'd0;
	localparam logic [1:0] MODE_INT = 2'd1;
	localparam logic [1:0] MODE_LONG = 2'd2;

	typedef enum logic [2:0] {
		S_IDLE,
		S_CONV,
		S_LEAD,
		S_EMPTY,
		S_SIGN,
		S_DIGIT
	} state_t;

	typedef struct packed {
		logic clear;
		logic dabble;
		logic shift;
	} cell_ctrl_t;

endpackage

/* rtl/sdf_cell.sv */
module sdf_cell (
	input  logic               clk,
	input  sdf_pkg::cell_ctrl_t ctrl,
	input  logic               bit_in,
	input  logic [3:0]         digit_in,
	output logic [3:0]         digit,
	output logic               bit_out
);
	import sdf_pkg::*;

	logic [3:0] digit_q;
	logic [3:0] adj;

	// Add three before the shift so the digit carries into its neighbor at ten.
	assign adj = (digit_q >= 4'd5) ? digit_q + 4'd3 : digit_q;
	assign bit_out = adj[3];
	assign digit = digit_q;

	always_ff @(posedge clk) begin
		if (ctrl.clear) begin
			digit_q <= 4'd0;
		end else if (ctrl.dabble) begin
			digit_q <= {adj[2:0], bit_in};
		end else if (ctrl.shift) begin
			digit_q <= digit_in;
		end
	end

endmodule

/* rtl/signed_decimal_formatter_core.sv */
// Formats a signed integer as decimal ASCII, most significant character first: an
// optional '-', then the digits, with last set on the final character. A zero value
// with zero_precision set gives one word with empty_text set and no character. The
// value is converted bit-serially by a chain of twenty BCD cells (shift and add three),
// one bit per cycle. The same chain then shifts digits toward its top end: leading
// zeros are shifted out first, then each digit character is emitted with one shift
// while the output side does not stall. The next number is accepted only once the
// last word of this one is in the output register.
module signed_decimal_formatter_core #(
	parameter int VALUE_BITS = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [63:0] value,
	input  logic [1:0]  mode,
	input  logic        zero_precision,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [6:0]  character,
	output logic        empty_text,
	output logic        last
);
	import sdf_pkg::*;

	localparam int W_SHORT = 16;
	localparam int W_INT = (VALUE_BITS < 32) ? VALUE_BITS : 32;
	localparam int CNT_W = (VALUE_BITS > 1) ? $clog2(VALUE_BITS) : 1;

	state_t state_q, state_d;

	logic [VALUE_BITS-1:0] mag_q;
	logic [CNT_W-1:0]      bit_cnt_q;
	logic [DCNT_W-1:0]     dig_cnt_q;
	logic                  neg_q;
	logic                  empty_q;

	logic                  out_valid_q;
	logic [6:0]            char_q;
	logic                  empty_text_q;
	logic                  last_q;

	logic [VALUE_BITS-1:0] v_ext;
	logic                  v_neg;
	logic [VALUE_BITS-1:0] v_mag;
	logic                  accept;
	logic                  can_push;
	logic                  push;
	logic [6:0]            push_char;
	logic                  push_empty;
	logic                  push_last;
	logic                  skip;
	cell_ctrl_t            ctrl;

	logic [3:0] digit_w [NDIG];
	logic       carry_w [NDIG];

	// Truncate to the selected width and sign-extend.
	always_comb begin
		case (mode)
			MODE_SHORT: v_ext = VALUE_BITS'($signed(value[W_SHORT-1:0]));
			MODE_LONG:  v_ext = value[VALUE_BITS-1:0];
			default:    v_ext = VALUE_BITS'($signed(value[W_INT-1:0]));
		endcase
	end

	assign v_neg = v_ext[VALUE_BITS-1];
	assign v_mag = v_neg ? (~v_ext + 1'b1) : v_ext;

	assign accept = in_valid && !in_stall;
	assign in_stall = (state_q != S_IDLE);
	assign can_push = !out_valid_q || !out_stall;
	assign skip = (digit_w[NDIG-1] == 4'd0) && (dig_cnt_q > DCNT_W'(1));

	for (genvar i = 0; i < NDIG; i++) begin : g_chain
		logic       bit_in;
		logic [3:0] digit_in;
		if (i == 0) begin : g_first
			assign bit_in = mag_q[VALUE_BITS-1];
			assign digit_in = 4'd0;
		end else begin : g_rest
			assign bit_in = carry_w[i-1];
			assign digit_in = digit_w[i-1];
		end
		sdf_cell u_cell (
			.clk      (clk),
			.ctrl     (ctrl),
			.bit_in   (bit_in),
			.digit_in (digit_in),
			.digit    (digit_w[i]),
			.bit_out  (carry_w[i])
		);
	end

	// Next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (accept) state_d = S_CONV;
			end
			S_CONV: begin
				if (bit_cnt_q == '0) state_d = empty_q ? S_EMPTY : S_LEAD;
			end
			S_LEAD: begin
				if (!skip) state_d = neg_q ? S_SIGN : S_DIGIT;
			end
			S_EMPTY: begin
				if (can_push) state_d = S_IDLE;
			end
			S_SIGN: begin
				if (can_push) state_d = S_DIGIT;
			end
			S_DIGIT: begin
				if (can_push && dig_cnt_q == DCNT_W'(1)) state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	// Outputs of the sequencer
	always_comb begin
		ctrl = '0;
		push = 1'b0;
		push_char = CH_ZERO;
		push_empty = 1'b0;
		push_last = 1'b0;
		case (state_q)
			S_IDLE: begin
				ctrl.clear = accept;
			end
			S_CONV: begin
				ctrl.dabble = 1'b1;
			end
			S_LEAD: begin
				ctrl.shift = skip;
			end
			S_EMPTY: begin
				push = can_push;
				push_char = 7'd0;
				push_empty = 1'b1;
				push_last = 1'b1;
			end
			S_SIGN: begin
				push = can_push;
				push_char = CH_MINUS;
			end
			S_DIGIT: begin
				push = can_push;
				push_char = CH_ZERO + {3'd0, digit_w[NDIG-1]};
				push_last = (dig_cnt_q == DCNT_W'(1));
				ctrl.shift = can_push;
			end
			default: begin
				ctrl = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			bit_cnt_q <= '0;
			dig_cnt_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (accept) begin
				bit_cnt_q <= CNT_W'(VALUE_BITS - 1);
				dig_cnt_q <= DCNT_W'(NDIG);
			end else begin
				if (state_q == S_CONV && bit_cnt_q != '0) bit_cnt_q <= bit_cnt_q - 1'b1;
				if (ctrl.shift) dig_cnt_q <= dig_cnt_q - 1'b1;
			end
			if (push) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			mag_q <= v_mag;
			neg_q <= v_neg;
			empty_q <= (v_ext == '0) && zero_precision;
		end else if (ctrl.dabble) begin
			mag_q <= {mag_q[VALUE_BITS-2:0], 1'b0};
		end
		if (push) begin
			char_q <= push_char;
			empty_text_q <= push_empty;
			last_q <= push_last;
		end
	end

	assign out_valid = out_valid_q;
	assign character = char_q;
	assign empty_text = empty_text_q;
	assign last = last_q;

	a_accept_conv: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> state_q == S_CONV)
		else $error("word accepted but conversion did not start");

	a_empty_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && empty_text |-> last)
		else $error("empty text word not marked last");

	a_digit_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_DIGIT |-> dig_cnt_q != '0)
		else $error("digit emission with no digits left");

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_CONV |-> !carry_w[NDIG-1])
		else $error("cell chain overflow during conversion");

endmodule
